/* src/wfr_pkg.sv */
// ----------------------------------------------------------------------------
// wfr_pkg
// Types, constants and opcode helpers shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package wfr_pkg;

   // Frame opcodes.
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // Seven-bit length codes that announce an extended length.
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   // Header byte counts.
   localparam int unsigned HDR_CNT_W = 4;
   localparam logic [HDR_CNT_W-1:0] EXT16_BYTES = 4'd2;
   localparam logic [HDR_CNT_W-1:0] EXT64_BYTES = 4'd8;
   localparam logic [HDR_CNT_W-1:0] KEY_BYTES   = 4'd4;
   localparam logic [HDR_CNT_W-1:0] CNT_ZERO    = 4'd0;
   localparam logic [HDR_CNT_W-1:0] CNT_ONE     = 4'd1;

   // Queue between parser and output stage.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_PAY  = 3'd4
   } phase_type;

   // One classified event from the parser: a payload byte still masked,
   // the key byte that unmasks it, and the frame context.
   typedef struct packed {
      logic [7:0] raw_byte;
      logic [7:0] key_byte;
      logic       has_byte;
      logic       frame_end;
      logic [3:0] opcode;
      logic       fin;
   } queue_entry_type;

   function automatic logic is_data(input logic [3:0] op);
      return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY);
   endfunction

   function automatic logic is_delivered(input logic [3:0] op);
      return is_data(op) || (op == OP_PING);
   endfunction

   function automatic logic is_close(input logic [3:0] op);
      return !is_delivered(op) && (op != OP_PONG);
   endfunction

endpackage

/* src/wfr_front.sv */
// ----------------------------------------------------------------------------
// wfr_front
// Header parser: walks each received byte through the frame header, tracks
// length and masking key, and pushes classified payload events to the queue.
// ----------------------------------------------------------------------------
module wfr_front #(
   parameter int unsigned LENGTH_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               rx_byte,
   output logic                     push,
   output wfr_pkg::queue_entry_type entry
);
   import wfr_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [HDR_CNT_W-1:0]   cnt_ff, cnt_in, cnt_dec;
   logic                   fin_ff, fin_in;
   logic [3:0]             opcode_ff, opcode_in;
   logic                   mask_ff, mask_in;
   logic [31:0]            key_ff, key_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in, len_shift, len_dec;
   logic [1:0]             kpos_ff, kpos_in;
   logic [6:0]             len_code;
   logic [7:0]             key_byte;
   logic                   deliver;
   logic                   last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         cnt_ff    <= CNT_ZERO;
         fin_ff    <= 1'b0;
         opcode_ff <= OP_CONT;
         mask_ff   <= 1'b0;
         key_ff    <= '0;
         len_ff    <= '0;
         kpos_ff   <= 2'd0;
      end else begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         key_ff    <= key_in;
         len_ff    <= len_in;
         kpos_ff   <= kpos_in;
      end
   end

   always_comb begin
      case (kpos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign len_code  = rx_byte[6:0];
   assign len_shift = {len_ff[LENGTH_BITS-9:0], rx_byte};
   assign len_dec   = len_ff - LENGTH_BITS'(1);
   assign cnt_dec   = cnt_ff - CNT_ONE;
   assign deliver   = is_delivered(opcode_ff);
   assign last      = (len_ff == LENGTH_BITS'(1));

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      key_in    = key_ff;
      len_in    = len_ff;
      kpos_in   = kpos_ff;
      push      = 1'b0;

      entry.raw_byte  = rx_byte;
      entry.key_byte  = key_byte;
      entry.has_byte  = 1'b0;
      entry.frame_end = 1'b0;
      entry.opcode    = opcode_ff;
      entry.fin       = fin_ff;

      if (accept) begin
         case (phase_ff)
            PH_HDR1: begin
               mask_in = rx_byte[7];
               if (len_code == LEN_CODE_EXT16) begin
                  len_in   = '0;
                  phase_in = PH_EXT;
                  cnt_in   = EXT16_BYTES;
               end else if (len_code == LEN_CODE_EXT64) begin
                  len_in   = '0;
                  phase_in = PH_EXT;
                  cnt_in   = EXT64_BYTES;
               end else begin
                  len_in = LENGTH_BITS'(len_code);
                  if (rx_byte[7]) begin
                     phase_in = PH_KEY;
                     cnt_in   = KEY_BYTES;
                  end else if (len_code == 7'd0) begin
                     phase_in        = PH_HDR0;
                     push            = 1'b1;
                     entry.frame_end = 1'b1;
                  end else begin
                     phase_in = PH_PAY;
                  end
               end
            end
            PH_EXT: begin
               len_in = len_shift;
               cnt_in = cnt_dec;
               if (cnt_dec == CNT_ZERO) begin
                  if (mask_ff) begin
                     phase_in = PH_KEY;
                     cnt_in   = KEY_BYTES;
                  end else if (len_shift == '0) begin
                     phase_in        = PH_HDR0;
                     push            = 1'b1;
                     entry.frame_end = 1'b1;
                  end else begin
                     phase_in = PH_PAY;
                  end
               end
            end
            PH_KEY: begin
               key_in = {key_ff[23:0], rx_byte};
               cnt_in = cnt_dec;
               if (cnt_dec == CNT_ZERO) begin
                  if (len_ff == '0) begin
                     phase_in        = PH_HDR0;
                     push            = 1'b1;
                     entry.frame_end = 1'b1;
                  end else begin
                     phase_in = PH_PAY;
                  end
               end
            end
            PH_PAY: begin
               kpos_in = kpos_ff + 2'd1;
               len_in  = len_dec;
               if (last) begin
                  phase_in = PH_HDR0;
               end
               push            = deliver || last;
               entry.has_byte  = deliver;
               entry.frame_end = last;
            end
            default: begin
               // First header byte; unused phase codes restart here as well.
               fin_in    = rx_byte[7];
               opcode_in = rx_byte[3:0];
               mask_in   = 1'b0;
               key_in    = '0;
               kpos_in   = 2'd0;
               cnt_in    = CNT_ZERO;
               len_in    = '0;
               phase_in  = PH_HDR1;
            end
         endcase
      end
   end

endmodule

/* src/wfr_queue.sv */
// ----------------------------------------------------------------------------
// wfr_queue
// Two-entry queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
module wfr_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  wfr_pkg::queue_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     not_empty,
   output wfr_pkg::queue_entry_type head_entry
);
   import wfr_pkg::*;

   queue_entry_type        slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty  = (count_ff != '0);
   assign do_push    = push && !full;
   assign do_pop     = pop && not_empty;
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     QUEUE_PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     QUEUE_PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* src/wfr_back.sv */
// ----------------------------------------------------------------------------
// wfr_back
// Output stage: unmasks the payload byte, derives the message and close
// marks, and holds the result in a register until it is transferred.
// ----------------------------------------------------------------------------
module wfr_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  wfr_pkg::queue_entry_type head_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_payload_byte,
   output logic                     rsp_has_byte,
   output logic [3:0]               rsp_frame_opcode,
   output logic                     rsp_final_fragment,
   output logic                     rsp_frame_end,
   output logic                     rsp_message_end,
   output logic                     rsp_close_request
);
   import wfr_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       has_ff, has_in;
   logic [3:0] opcode_ff, opcode_in;
   logic       fin_ff, fin_in;
   logic       end_ff, end_in;
   logic       msg_end_ff, msg_end_in;
   logic       close_ff, close_in;
   logic       load;

   // The register takes a new result when it is empty or being drained.
   assign load = !valid_ff || rsp_ready;
   assign pop  = load && head_valid;

   always_comb begin
      valid_in   = load ? head_valid : valid_ff;
      byte_in    = head_entry.has_byte ? (head_entry.raw_byte ^ head_entry.key_byte) : 8'd0;
      has_in     = head_entry.has_byte;
      opcode_in  = head_entry.opcode;
      fin_in     = head_entry.fin;
      end_in     = head_entry.frame_end;
      msg_end_in = head_entry.frame_end && head_entry.fin && is_data(head_entry.opcode);
      close_in   = head_entry.frame_end && is_close(head_entry.opcode);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_ff    <= byte_in;
         has_ff     <= has_in;
         opcode_ff  <= opcode_in;
         fin_ff     <= fin_in;
         end_ff     <= end_in;
         msg_end_ff <= msg_end_in;
         close_ff   <= close_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_payload_byte   = byte_ff;
   assign rsp_has_byte       = has_ff;
   assign rsp_frame_opcode   = opcode_ff;
   assign rsp_final_fragment = fin_ff;
   assign rsp_frame_end      = end_ff;
   assign rsp_message_end    = msg_end_ff;
   assign rsp_close_request  = close_ff;

endmodule

/* src/websocket_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// websocket_frame_receiver_top
// Frame receiver: parses frame headers and delivers unmasked payload bytes.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle, sustained, for as long
// as results are taken at the same pace. The header parser handles each byte
// in the cycle it is transferred and hands payload and frame-end events to a
// two-entry queue; an output register then presents them. req_ready drops
// only when the queue is full, which happens only while rsp_ready is held
// low. Header bytes and dropped payload bytes produce no result, except the
// byte that ends a frame, which always yields a frame-end result.
module websocket_frame_receiver_top #(
   parameter int unsigned LENGTH_BITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_has_byte,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_final_fragment,
   output logic       rsp_frame_end,
   output logic       rsp_message_end,
   output logic       rsp_close_request
);
   import wfr_pkg::*;

   queue_entry_type push_entry;
   queue_entry_type head_entry;
   logic            push;
   logic            full;
   logic            head_valid;
   logic            pop;
   logic            accept;

   assign req_ready = !full;
   assign accept    = req_valid && !full;

   wfr_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .push    (push),
      .entry   (push_entry)
   );

   wfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .not_empty  (head_valid),
      .head_entry (head_entry)
   );

   wfr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_entry         (head_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_has_byte       (rsp_has_byte),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_final_fragment (rsp_final_fragment),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_message_end    (rsp_message_end),
      .rsp_close_request  (rsp_close_request)
   );

endmodule

/* src/wfr_checker.sv */
// ----------------------------------------------------------------------------
// wfr_checker
// Port-level checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
module wfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_has_byte,
   input logic [3:0] rsp_frame_opcode,
   input logic       rsp_final_fragment,
   input logic       rsp_frame_end,
   input logic       rsp_message_end,
   input logic       rsp_close_request
);
   import wfr_pkg::*;

   // A stalled result stays valid and keeps its byte and frame-end mark until it is transferred.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(rsp_valid) && !$past(rsp_ready) |->
         rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_frame_end))
      else $error("stalled result changed");

   // A message ends only at the end of a final fragment.
   a_msg_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_end |-> rsp_frame_end && rsp_final_fragment)
      else $error("message end outside a final frame end");

   // Close requests come only from frames whose bytes are never delivered.
   a_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_close_request |-> rsp_frame_end && !rsp_has_byte)
      else $error("close request on a delivered byte");

   // Only data and ping frames deliver payload bytes.
   a_deliver: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_byte |->
         rsp_frame_opcode == OP_CONT || rsp_frame_opcode == OP_TEXT ||
         rsp_frame_opcode == OP_BINARY || rsp_frame_opcode == OP_PING)
      else $error("payload byte delivered for a dropped opcode");

   // A result without a byte carries a zero byte and marks a frame end.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_payload_byte == 8'd0 && rsp_frame_end)
      else $error("empty result is malformed");

endmodule

bind websocket_frame_receiver_top wfr_checker u_wfr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_has_byte       (rsp_has_byte),
   .rsp_frame_opcode   (rsp_frame_opcode),
   .rsp_final_fragment (rsp_final_fragment),
   .rsp_frame_end      (rsp_frame_end),
   .rsp_message_end    (rsp_message_end),
   .rsp_close_request  (rsp_close_request)
);

/* tb/tb_websocket_frame_receiver_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_receiver_top
// Self-checking bench for the frame receiver. It runs a short directed burst
// of hand-built frames, then a long run of random frames. Some are well-formed
// and some are header noise, and random gaps fall on both handshakes. A
// byte-level model of the parser predicts each result not typed in by hand,
// and each result is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_websocket_frame_receiver_top;
   import wfr_pkg::*;

   localparam int unsigned LEN_BITS = 64;
   localparam int unsigned RANDOM_BYTES = 1750;
   localparam int unsigned QUIET_TAIL = 200;
   localparam int unsigned DIRECTED_ROWS = 24;

   // An opcode that the protocol leaves undefined.
   localparam logic [3:0] OP_UNKNOWN = 4'h3;

   typedef struct packed {
      logic [7:0] payload;
      logic       has_byte;
      logic [3:0] opcode;
      logic       fin;
      logic       frame_end;
      logic       message_end;
      logic       close_request;
   } rx_result_type;

   typedef enum logic [1:0] {
      CLS_DATA,
      CLS_PING,
      CLS_PONG,
      CLS_CLOSE
   } op_class_type;

   // One directed stimulus row: the byte, and a result typed in by hand.
   typedef struct packed {
      logic [7:0]    rx;
      logic          typed;
      rx_result_type want;
   } dir_row_type;

   localparam dir_row_type DIRECTED [DIRECTED_ROWS] = '{
      // Empty final text frame: the second header byte closes the message.
      {8'h81, 1'b0, 17'h0},
      {8'h00, 1'b1, {8'h00, 1'b0, OP_TEXT, 1'b1, 1'b1, 1'b1, 1'b0}},
      // Masked close with no payload: the frame ends on the last key byte.
      {8'h88, 1'b0, 17'h0},
      {8'h80, 1'b0, 17'h0},
      {8'hFF, 1'b0, 17'h0},
      {8'h00, 1'b0, 17'h0},
      {8'hFF, 1'b0, 17'h0},
      {8'h00, 1'b1, {8'h00, 1'b0, OP_CLOSE, 1'b1, 1'b1, 1'b0, 1'b1}},
      // Unmasked continuation fragment, extreme byte values pass unchanged.
      {8'h00, 1'b0, 17'h0},
      {8'h02, 1'b0, 17'h0},
      {8'h00, 1'b1, {8'h00, 1'b1, OP_CONT, 1'b0, 1'b0, 1'b0, 1'b0}},
      {8'hFF, 1'b1, {8'hFF, 1'b1, OP_CONT, 1'b0, 1'b1, 1'b0, 1'b0}},
      // Masked ping with a 16-bit extended length of one.
      {8'h89, 1'b0, 17'h0},
      {8'hFE, 1'b0, 17'h0},
      {8'h00, 1'b0, 17'h0},
      {8'h01, 1'b0, 17'h0},
      {8'hA5, 1'b0, 17'h0},
      {8'h5A, 1'b0, 17'h0},
      {8'hC3, 1'b0, 17'h0},
      {8'h3C, 1'b0, 17'h0},
      {8'h7E, 1'b0, 17'h0},
      // Reserved bits set and an unknown opcode: payload dropped, close flagged.
      {8'h73, 1'b0, 17'h0},
      {8'h01, 1'b0, 17'h0},
      {8'hAB, 1'b1, {8'h00, 1'b0, OP_UNKNOWN, 1'b0, 1'b1, 1'b0, 1'b1}}
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_payload_byte;
   logic       rsp_has_byte;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_final_fragment;
   logic       rsp_frame_end;
   logic       rsp_message_end;
   logic       rsp_close_request;

   // Stimulus bytes, and for some directed bytes a result typed in by hand.
   logic [7:0]    stim_byte[$];
   bit            stim_typed[$];
   rx_result_type stim_want[$];

   // Sideband of the byte currently offered on the request channel.
   bit            item_typed;
   rx_result_type item_want;

   rx_result_type pending_results[$];
   int            error_count;
   bit            quiet;

   // Parser model state.
   phase_type            rx_phase;
   logic [3:0]           hdr_left;
   logic                 fin_q;
   logic [3:0]           op_q;
   logic                 masked_q;
   logic [31:0]          key_q;
   logic [LEN_BITS-1:0]  len_left;
   logic [1:0]           key_idx;

   websocket_frame_receiver_top #(
      .LENGTH_BITS(LEN_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_has_byte       (rsp_has_byte),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_final_fragment (rsp_final_fragment),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_message_end    (rsp_message_end),
      .rsp_close_request  (rsp_close_request)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------
   function automatic op_class_type classify(input logic [3:0] op);
      case (op)
         OP_CONT, OP_TEXT, OP_BINARY: return CLS_DATA;
         OP_PING:                     return CLS_PING;
         OP_PONG:                     return CLS_PONG;
         default:                     return CLS_CLOSE;
      endcase
   endfunction

   function automatic rx_result_type frame_result(input logic [7:0] b, input logic has,
                                                  input logic fe);
      rx_result_type r;
      r.payload       = has ? b : 8'h00;
      r.has_byte      = has;
      r.opcode        = op_q;
      r.fin           = fin_q;
      r.frame_end     = fe;
      r.message_end   = fe && fin_q && (classify(op_q) == CLS_DATA);
      r.close_request = fe && (classify(op_q) == CLS_CLOSE);
      return r;
   endfunction

   task automatic predictor_reset();
      rx_phase = PH_HDR0;
      hdr_left = CNT_ZERO;
      fin_q    = 1'b0;
      op_q     = OP_CONT;
      masked_q = 1'b0;
      key_q    = '0;
      len_left = '0;
      key_idx  = '0;
   endtask

   // Header done: a frame with nothing to carry ends right here.
   function automatic bit start_payload(output rx_result_type r);
      r = '0;
      if (len_left == 0) begin
         rx_phase = PH_HDR0;
         r = frame_result(8'h00, 1'b0, 1'b1);
         return 1'b1;
      end
      rx_phase = PH_PAY;
      return 1'b0;
   endfunction

   function automatic bit length_done(output rx_result_type r);
      r = '0;
      if (masked_q) begin
         rx_phase = PH_KEY;
         hdr_left = KEY_BYTES;
         return 1'b0;
      end
      return start_payload(r);
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, output rx_result_type r);
      logic [7:0] plain;
      bit         deliver;
      bit         last;
      r = '0;
      parse_byte = 1'b0;
      case (rx_phase)
         PH_HDR1: begin
            masked_q = b[7];
            len_left = '0;
            if (b[6:0] == LEN_CODE_EXT16) begin
               rx_phase = PH_EXT;
               hdr_left = EXT16_BYTES;
            end else if (b[6:0] == LEN_CODE_EXT64) begin
               rx_phase = PH_EXT;
               hdr_left = EXT64_BYTES;
            end else begin
               len_left = LEN_BITS'(b[6:0]);
               parse_byte = length_done(r);
            end
         end
         PH_EXT: begin
            len_left = {len_left[LEN_BITS-9:0], b};
            hdr_left = hdr_left - 1'b1;
            if (hdr_left == CNT_ZERO) parse_byte = length_done(r);
         end
         PH_KEY: begin
            key_q = {key_q[23:0], b};
            hdr_left = hdr_left - 1'b1;
            if (hdr_left == CNT_ZERO) parse_byte = start_payload(r);
         end
         PH_PAY: begin
            // Key bytes are taken most significant first.
            plain    = b ^ key_q[31 - 8*key_idx -: 8];
            deliver  = classify(op_q) inside {CLS_DATA, CLS_PING};
            key_idx  = key_idx + 1'b1;
            len_left = len_left - 1'b1;
            last     = (len_left == 0);
            if (last) rx_phase = PH_HDR0;
            if (deliver || last) begin
               r = frame_result(plain, deliver, last);
               parse_byte = 1'b1;
            end
         end
         default: begin
            fin_q    = b[7];
            op_q     = b[3:0];
            masked_q = 1'b0;
            key_q    = '0;
            key_idx  = '0;
            hdr_left = CNT_ZERO;
            len_left = '0;
            rx_phase = PH_HDR1;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------------
   task automatic queue_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input rx_result_type want = '0);
      stim_byte.push_back(b);
      stim_typed.push_back(typed);
      stim_want.push_back(want);
   endtask

   task automatic build_directed();
      for (int unsigned i = 0; i < DIRECTED_ROWS; i++)
         queue_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].want);
   endtask

   task automatic build_random_frame(input bit noise);
      logic [7:0]      hdr0;
      logic [3:0]      op;
      logic            masked;
      logic [6:0]      code;
      longint unsigned len;
      int unsigned     ext_bytes;
      int unsigned     sel;
      masked    = 1'($urandom_range(0, 1));
      ext_bytes = 0;
      if (noise) begin
         hdr0 = 8'($urandom_range(0, 255));
         len  = 64'($urandom_range(0, 125));
      end else begin
         sel = $urandom_range(0, 13);
         case (sel)
            0, 1:    op = OP_CONT;
            2, 3:    op = OP_TEXT;
            4, 5:    op = OP_BINARY;
            6, 7:    op = OP_PING;
            8:       op = OP_PONG;
            9:       op = OP_CLOSE;
            default: op = 4'($urandom_range(0, 15));
         endcase
         hdr0 = {1'($urandom_range(0, 1)), 3'b000, op};
         if ($urandom_range(0, 7) == 0) hdr0[6:4] = 3'($urandom_range(0, 7));
         sel = $urandom_range(0, 19);
         if (sel < 2) len = 0;
         else if (sel < 14) len = 64'($urandom_range(1, 12));
         else if (sel == 14) len = 125;
         else if (sel == 15) len = 64'($urandom_range(13, 124));
         else if (sel == 16 || sel == 18) begin
            ext_bytes = 2;
            len = (sel == 16) ? 64'($urandom_range(0, 300)) : 64'($urandom_range(0, 10));
         end else begin
            ext_bytes = 8;
            len = (sel == 17) ? 64'($urandom_range(0, 40)) : 64'($urandom_range(0, 10));
         end
      end
      if (ext_bytes == 2) code = LEN_CODE_EXT16;
      else if (ext_bytes == 8) code = LEN_CODE_EXT64;
      else code = len[6:0];
      queue_byte(hdr0);
      queue_byte({masked, code});
      for (int k = ext_bytes - 1; k >= 0; k--) queue_byte(8'(len >> (8*k)));
      if (masked) repeat (4) queue_byte(8'($urandom_range(0, 255)));
      for (longint unsigned k = 0; k < len; k++) queue_byte(8'($urandom_range(0, 255)));
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   function automatic string show(input rx_result_type r);
      return $sformatf("byte=%02h has=%0d op=%0h fin=%0d end=%0d msg=%0d close=%0d",
                       r.payload, r.has_byte, r.opcode, r.fin, r.frame_end,
                       r.message_end, r.close_request);
   endfunction

   task automatic report_error(input string msg);
      if (error_count < 10) $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_result(input rx_result_type got);
      rx_result_type want;
      if (pending_results.size() == 0) begin
         report_error({"unexpected result: ", show(got)});
         return;
      end
      want = pending_results.pop_front();
      if (got.payload !== want.payload || got.has_byte !== want.has_byte ||
          got.opcode !== want.opcode || got.fin !== want.fin ||
          got.frame_end !== want.frame_end || got.message_end !== want.message_end ||
          got.close_request !== want.close_request)
         report_error({"expected ", show(want), " got ", show(got)});
   endtask

   always @(posedge clock) begin : monitor
      rx_result_type predicted;
      bit            produced;
      if (reset) begin
         predictor_reset();
      end else begin
         if (req_valid && req_ready) begin
            produced = parse_byte(req_rx_byte, predicted);
            if (item_typed) pending_results.push_back(item_want);
            else if (produced) pending_results.push_back(predicted);
         end
         if (rsp_valid && rsp_ready)
            check_result({rsp_payload_byte, rsp_has_byte, rsp_frame_opcode,
                          rsp_final_fragment, rsp_frame_end, rsp_message_end,
                          rsp_close_request});
      end
   end

   // ------------------------------------------------------------------------
   // Result side: random stall bursts until the quiet tail of the run.
   // ------------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int unsigned total;
      int unsigned drain_cycles;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      item_typed  = 1'b0;
      item_want   = '0;
      quiet       = 1'b0;
      error_count = 0;

      build_directed();
      while (stim_byte.size() < RANDOM_BYTES + DIRECTED_ROWS)
         build_random_frame($urandom_range(0, 9) == 0);
      total = stim_byte.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int unsigned i = 0; i < total; i++) begin
         quiet = (i + QUIET_TAIL >= total);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_rx_byte <= stim_byte[i];
         item_typed  <= stim_typed[i];
         item_want   <= stim_want[i];
         do @(posedge clock); while (!req_ready);
      end
      req_valid  <= 1'b0;
      item_typed <= 1'b0;

      drain_cycles = 0;
      while (pending_results.size() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      // Let any result the block still holds show up as unexpected.
      repeat (20) @(posedge clock);
      while (pending_results.size() != 0)
         report_error({"missing result: ", show(pending_results.pop_front())});

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* sim.f */
src/wfr_pkg.sv
src/wfr_front.sv
src/wfr_queue.sv
src/wfr_back.sv
src/websocket_frame_receiver_top.sv
src/wfr_checker.sv
tb/tb_websocket_frame_receiver_top.sv
